### src/i2c_master_fast_write_and_bitbang_read_defines.svh
// Assertion macros shared by the checker of the sensor-bus master.
`ifndef I2C_MASTER_FAST_WRITE_AND_BITBANG_READ_DEFINES_SVH
`define I2C_MASTER_FAST_WRITE_AND_BITBANG_READ_DEFINES_SVH

// Implication in the same cycle, off while reset is high.
`define I2CM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the next cycle, off while reset is high.
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// What must hold in the cycle after reset was seen high.
`define I2CM_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

### src/i2cm_pkg.sv
package i2cm_pkg;

  // Job types passed from the front end to the sequencer.
  localparam logic [2:0] J_WRITE  = 3'd0;
  localparam logic [2:0] J_RBEGIN = 3'd1;
  localparam logic [2:0] J_ACK0   = 3'd2;
  localparam logic [2:0] J_ACK1   = 3'd3;
  localparam logic [2:0] J_STEP   = 3'd4;
  localparam logic [2:0] J_NACK   = 3'd5;
  localparam logic [2:0] J_FINAL  = 3'd6;

  // Entry types of a sequencer script.
  localparam logic [2:0] E_CTL      = 3'd0;
  localparam logic [2:0] E_BYTE     = 3'd1;
  localparam logic [2:0] E_FAST     = 3'd2;
  localparam logic [2:0] E_AWAIT    = 3'd3;
  localparam logic [2:0] E_FIN_DATA = 3'd4;
  localparam logic [2:0] E_FIN_ERR  = 3'd5;

  // Input opcodes.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Result kinds.
  localparam logic [1:0] K_CTL   = 2'd0;
  localparam logic [1:0] K_FAST  = 2'd1;
  localparam logic [1:0] K_AWAIT = 2'd2;
  localparam logic [1:0] K_DONE  = 2'd3;

  // Serial control words: bit5 fast-bus enable, bit4 SDE, bit1 SDA, bit0 SCL.
  localparam logic [5:0] CW_SDA0_SCL0 = 6'h10;
  localparam logic [5:0] CW_SDA0_SCL1 = 6'h11;
  localparam logic [5:0] CW_SDA1_SCL0 = 6'h12;
  localparam logic [5:0] CW_SDA1_SCL1 = 6'h13;
  localparam logic [5:0] CW_FAST_BUS  = 6'h30;

  // Sample steps: three acknowledges, then data bits 7 down to 0.
  localparam logic [3:0] STEP_ACK0     = 4'd0;
  localparam logic [3:0] STEP_ACK1     = 4'd1;
  localparam logic [3:0] STEP_ACK2     = 4'd2;
  localparam logic [3:0] STEP_LAST_BIT = 4'd10;

  localparam int JQ_DEPTH = 4;
  localparam int JQ_PTR_W = $clog2(JQ_DEPTH);

  localparam logic [15:0] TAIL_REGISTER = 16'h001d;
  localparam logic [15:0] TAIL_VALUE    = 16'hfe1d;

  typedef struct packed {
    logic [2:0] jtype;
    logic [7:0] b0;
    logic [7:0] b1;
  } job_t;

  typedef struct packed {
    logic [2:0] etype;
    logic [5:0] cw;
    logic       last;
  } entry_t;

  function automatic logic [63:0] address_word(input logic [7:0] a);
    logic [15:0] w0, w1, w2, w3;
    w0 = 16'h082f | (a[7] ? 16'h1500 : 16'h0) | (a[6] ? 16'h4000 : 16'h0);
    w1 = 16'h2082 | (a[6] ? 16'h0005 : 16'h0) | (a[5] ? 16'h0150 : 16'h0) |
         (a[4] ? 16'h5400 : 16'h0);
    w2 = 16'h8208 | (a[3] ? 16'h0015 : 16'h0) | (a[2] ? 16'h0540 : 16'h0) |
         (a[1] ? 16'h5000 : 16'h0);
    w3 = 16'h1d20 | (a[1] ? 16'h0001 : 16'h0) | (a[0] ? 16'h0054 : 16'h0);
    return {w3, w2, w1, w0};
  endfunction

  function automatic logic [63:0] byte_word(input logic [7:0] b, input logic [15:0] tail);
    logic [15:0] w0, w1, w2;
    w0 = 16'h8208 | (b[7] ? 16'h0015 : 16'h0) | (b[6] ? 16'h0540 : 16'h0) |
         (b[5] ? 16'h5000 : 16'h0);
    w1 = 16'h0820 | (b[5] ? 16'h0001 : 16'h0) | (b[4] ? 16'h0054 : 16'h0) |
         (b[3] ? 16'h1500 : 16'h0) | (b[2] ? 16'h4000 : 16'h0);
    w2 = 16'h2082 | (b[2] ? 16'h0005 : 16'h0) | (b[1] ? 16'h0150 : 16'h0) |
         (b[0] ? 16'h5400 : 16'h0);
    return {tail, w2, w1, w0};
  endfunction

  function automatic entry_t ent(input logic [2:0] et, input logic [5:0] cw,
                                 input logic lst);
    entry_t e;
    e.etype = et;
    e.cw    = cw;
    e.last  = lst;
    return e;
  endfunction

  // Script of each job: one entry per result, a byte entry stands for 24.
  function automatic entry_t seq_entry(input logic [2:0] jtype, input logic [3:0] idx);
    entry_t e;
    e = ent(E_CTL, CW_SDA1_SCL1, 1'b1);
    case (jtype)
      J_WRITE: begin
        e = ent(E_FAST, 6'd0, idx == 4'd2);
      end
      J_RBEGIN: begin
        case (idx)
          4'd0: e = ent(E_CTL, CW_SDA1_SCL1, 1'b0);
          4'd1: e = ent(E_CTL, CW_SDA0_SCL1, 1'b0);
          4'd2: e = ent(E_CTL, CW_SDA0_SCL0, 1'b0);
          4'd3: e = ent(E_BYTE, 6'd0, 1'b0);
          4'd4: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          4'd5: e = ent(E_CTL, CW_SDA1_SCL1, 1'b0);
          default: e = ent(E_AWAIT, 6'd0, 1'b1);
        endcase
      end
      J_ACK0: begin
        case (idx)
          4'd0: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          4'd1: e = ent(E_BYTE, 6'd0, 1'b0);
          4'd2: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          4'd3: e = ent(E_CTL, CW_SDA1_SCL1, 1'b0);
          default: e = ent(E_AWAIT, 6'd0, 1'b1);
        endcase
      end
      J_ACK1: begin
        case (idx)
          4'd0: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          4'd1: e = ent(E_CTL, CW_SDA0_SCL0, 1'b0);
          4'd2: e = ent(E_CTL, CW_SDA0_SCL1, 1'b0);
          4'd3: e = ent(E_CTL, CW_SDA1_SCL1, 1'b0);
          4'd4: e = ent(E_CTL, CW_SDA0_SCL1, 1'b0);
          4'd5: e = ent(E_CTL, CW_SDA0_SCL0, 1'b0);
          4'd6: e = ent(E_BYTE, 6'd0, 1'b0);
          4'd7: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          4'd8: e = ent(E_CTL, CW_SDA1_SCL1, 1'b0);
          default: e = ent(E_AWAIT, 6'd0, 1'b1);
        endcase
      end
      J_STEP: begin
        case (idx)
          4'd0: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          4'd1: e = ent(E_CTL, CW_SDA1_SCL1, 1'b0);
          default: e = ent(E_AWAIT, 6'd0, 1'b1);
        endcase
      end
      J_NACK: begin
        case (idx)
          4'd0: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          default: e = ent(E_FIN_ERR, 6'd0, 1'b1);
        endcase
      end
      J_FINAL: begin
        case (idx)
          4'd0: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          4'd1: e = ent(E_CTL, CW_SDA1_SCL1, 1'b0);
          4'd2: e = ent(E_CTL, CW_SDA1_SCL0, 1'b0);
          4'd3: e = ent(E_CTL, CW_SDA0_SCL0, 1'b0);
          4'd4: e = ent(E_CTL, CW_SDA0_SCL1, 1'b0);
          4'd5: e = ent(E_CTL, CW_SDA1_SCL1, 1'b0);
          4'd6: e = ent(E_CTL, CW_FAST_BUS, 1'b0);
          default: e = ent(E_FIN_DATA, 6'd0, 1'b1);
        endcase
      end
      default: e = ent(E_CTL, CW_SDA1_SCL1, 1'b1);
    endcase
    return e;
  endfunction

endpackage

### src/i2cm_front.sv
module i2cm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                q_full,
  input  logic [1:0]          opcode,
  input  logic [7:0]          target_register,
  input  logic [7:0]          write_value,
  input  logic                sda_level,
  input  logic [7:0]          sensor_address,
  output logic                full,
  output logic                job_push,
  output i2cm_pkg::job_t      job
);

  logic       busy, busy_next;
  logic [3:0] step_index, step_index_next;
  logic [7:0] latched_register, latched_register_next;
  logic [7:0] received_byte, received_byte_next;
  logic       accept;
  logic [7:0] shifted;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign shifted = {received_byte[6:0], sda_level};

  always_comb begin
    busy_next             = busy;
    step_index_next       = step_index;
    latched_register_next = latched_register;
    received_byte_next    = received_byte;
    job_push              = 1'b0;
    job.jtype             = i2cm_pkg::J_STEP;
    job.b0                = 8'd0;
    job.b1                = 8'd0;
    if (accept) begin
      if (opcode == i2cm_pkg::OP_WRITE && !busy) begin
        job_push  = 1'b1;
        job.jtype = i2cm_pkg::J_WRITE;
        job.b0    = target_register;
        job.b1    = write_value;
      end else if (opcode == i2cm_pkg::OP_READ && !busy) begin
        busy_next             = 1'b1;
        step_index_next       = i2cm_pkg::STEP_ACK0;
        latched_register_next = target_register;
        received_byte_next    = 8'd0;
        job_push              = 1'b1;
        job.jtype             = i2cm_pkg::J_RBEGIN;
        job.b0                = sensor_address;
      end else if (opcode == i2cm_pkg::OP_SAMPLE && busy) begin
        job_push = 1'b1;
        if (step_index <= i2cm_pkg::STEP_ACK2) begin
          if (sda_level) begin
            job.jtype       = i2cm_pkg::J_NACK;
            busy_next       = 1'b0;
            step_index_next = i2cm_pkg::STEP_ACK0;
          end else if (step_index == i2cm_pkg::STEP_ACK0) begin
            job.jtype       = i2cm_pkg::J_ACK0;
            job.b0          = latched_register;
            step_index_next = i2cm_pkg::STEP_ACK1;
          end else if (step_index == i2cm_pkg::STEP_ACK1) begin
            job.jtype       = i2cm_pkg::J_ACK1;
            job.b0          = sensor_address + 8'd1;
            step_index_next = i2cm_pkg::STEP_ACK2;
          end else begin
            job.jtype       = i2cm_pkg::J_STEP;
            step_index_next = step_index + 4'd1;
          end
        end else begin
          received_byte_next = shifted;
          if (step_index < i2cm_pkg::STEP_LAST_BIT) begin
            job.jtype       = i2cm_pkg::J_STEP;
            step_index_next = step_index + 4'd1;
          end else begin
            job.jtype       = i2cm_pkg::J_FINAL;
            job.b0          = shifted;
            busy_next       = 1'b0;
            step_index_next = i2cm_pkg::STEP_ACK0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      step_index <= i2cm_pkg::STEP_ACK0;
    end else begin
      busy       <= busy_next;
      step_index <= step_index_next;
    end
    latched_register <= latched_register_next;
    received_byte    <= received_byte_next;
  end

endmodule

### src/i2cm_jobq.sv
module i2cm_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  i2cm_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output i2cm_pkg::job_t head
);

  i2cm_pkg::job_t                  slots [i2cm_pkg::JQ_DEPTH];
  logic [i2cm_pkg::JQ_PTR_W-1:0]   wr_ptr;
  logic [i2cm_pkg::JQ_PTR_W-1:0]   rd_ptr;
  logic [i2cm_pkg::JQ_PTR_W:0]     count;
  logic                            do_push, do_pop;

  assign full    = (count == (i2cm_pkg::JQ_PTR_W + 1)'(i2cm_pkg::JQ_DEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### src/i2cm_back.sv
module i2cm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  i2cm_pkg::job_t cur,
  input  logic [7:0]     sensor_address,
  input  logic           pop,
  output logic           q_pop,
  output logic           empty,
  output logic [1:0]     kind,
  output logic [5:0]     control_word,
  output logic [63:0]    fast_bus_word,
  output logic [7:0]     read_data,
  output logic           nack_error,
  output logic           last
);

  logic [3:0]       idx;
  logic [2:0]       bitcnt;
  logic [1:0]       phase;
  logic             out_valid;
  logic             advance;
  logic             bit_val;
  i2cm_pkg::entry_t e;
  logic [1:0]       kind_next;
  logic [5:0]       cw_next;
  logic [63:0]      fb_next;
  logic [7:0]       rd_next;
  logic             ne_next;

  assign e       = i2cm_pkg::seq_entry(cur.jtype, idx);
  assign advance = q_valid && (!out_valid || pop);
  assign q_pop   = advance && e.last;
  assign empty   = !out_valid;
  assign bit_val = cur.b0[~bitcnt];

  always_comb begin
    kind_next = i2cm_pkg::K_CTL;
    cw_next   = 6'd0;
    fb_next   = 64'd0;
    rd_next   = 8'd0;
    ne_next   = 1'b0;
    case (e.etype)
      i2cm_pkg::E_CTL: begin
        cw_next = e.cw;
      end
      i2cm_pkg::E_BYTE: begin
        cw_next = {4'b0100, bit_val, phase == 2'd1};
      end
      i2cm_pkg::E_FAST: begin
        kind_next = i2cm_pkg::K_FAST;
        if (idx == 4'd0) begin
          fb_next = i2cm_pkg::address_word(sensor_address);
        end else if (idx == 4'd1) begin
          fb_next = i2cm_pkg::byte_word(cur.b0, i2cm_pkg::TAIL_REGISTER);
        end else begin
          fb_next = i2cm_pkg::byte_word(cur.b1, i2cm_pkg::TAIL_VALUE);
        end
      end
      i2cm_pkg::E_AWAIT: begin
        kind_next = i2cm_pkg::K_AWAIT;
      end
      i2cm_pkg::E_FIN_DATA: begin
        kind_next = i2cm_pkg::K_DONE;
        rd_next   = cur.b0;
      end
      i2cm_pkg::E_FIN_ERR: begin
        kind_next = i2cm_pkg::K_DONE;
        ne_next   = 1'b1;
      end
      default: begin
        kind_next = i2cm_pkg::K_CTL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 4'd0;
      bitcnt    <= 3'd0;
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (e.etype == i2cm_pkg::E_BYTE) begin
          if (phase == 2'd2) begin
            phase  <= 2'd0;
            bitcnt <= bitcnt + 3'd1;
            if (bitcnt == 3'd7) begin
              idx <= idx + 4'd1;
            end
          end else begin
            phase <= phase + 2'd1;
          end
        end else if (e.last) begin
          idx <= 4'd0;
        end else begin
          idx <= idx + 4'd1;
        end
      end
    end
    if (advance) begin
      kind          <= kind_next;
      control_word  <= cw_next;
      fast_bus_word <= fb_next;
      read_data     <= rd_next;
      nack_error    <= ne_next;
      last          <= e.last;
    end
  end

endmodule

### src/i2c_master_fast_write_and_bitbang_read.sv
// Channel   Handshake            Direction  Contents
// request   push / full          in         opcode, target_register, write_value, sda_level
// result    pop / empty          out        kind, control_word, fast_bus_word, read_data,
//                                           nack_error, last
// config    psel/penable/pwrite  in         sensor_address at byte address 0
//
// A request word is taken whenever the job queue has room.
// The sequencer then delivers one result word per cycle while they are popped: 3 for a
// write request, 30 for a read start, and 2 to 33 for an SDA sample; it sets the rate.
// The result register frees the sequencer as soon as its word is popped, so a
// held result only stalls the sequencer, and the front end keeps filling the queue.
// Synchronous reset empties the queue and the result register and leaves the
// master idle with sensor_address cleared.
module i2c_master_fast_write_and_bitbang_read (
  input  logic        clk,
  input  logic        rst,
  // Request side.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [7:0]  target_register,
  input  logic [7:0]  write_value,
  input  logic        sda_level,
  // Result side.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [5:0]  control_word,
  output logic [63:0] fast_bus_word,
  output logic [7:0]  read_data,
  output logic        nack_error,
  output logic        last,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           [7:0] sensor_address;
  logic                 q_full;
  logic                 job_push;
  i2cm_pkg::job_t       job;
  logic                 q_valid;
  i2cm_pkg::job_t       q_head;
  logic                 q_pop;
  logic                 reg_hit;

  // The only register sits at byte address 0; bit 2 selects the next word.
  assign reg_hit = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {24'd0, sensor_address} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_address <= 8'd0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sensor_address <= pwdata[7:0];
    end
  end

  // The front end tracks the read transaction and turns each word that fits its state into a job.
  i2cm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .q_full          (q_full),
    .opcode          (opcode),
    .target_register (target_register),
    .write_value     (write_value),
    .sda_level       (sda_level),
    .sensor_address  (sensor_address),
    .full            (full),
    .job_push        (job_push),
    .job             (job)
  );

  // Jobs wait here so that the front end waits on the result side only when the queue is full.
  i2cm_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  // The sequencer expands the head job into result words, one per cycle while they are popped.
  i2cm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .cur            (q_head),
    .sensor_address (sensor_address),
    .pop            (pop),
    .q_pop          (q_pop),
    .empty          (empty),
    .kind           (kind),
    .control_word   (control_word),
    .fast_bus_word  (fast_bus_word),
    .read_data      (read_data),
    .nack_error     (nack_error),
    .last           (last)
  );

endmodule

### src/i2cm_checker.sv
`include "i2c_master_fast_write_and_bitbang_read_defines.svh"

module i2cm_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind,
  input logic [5:0]  control_word,
  input logic [63:0] fast_bus_word,
  input logic [7:0]  read_data,
  input logic        nack_error,
  input logic        last
);

  `I2CM_ASSERT_AFTER_RESET(a_reset_empty, empty, "result side not empty after reset")

  `I2CM_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(kind) && $stable(fast_bus_word) && $stable(last), "waiting result changed")

  `I2CM_ASSERT_SAME(a_fast_only, !empty && kind != i2cm_pkg::K_FAST, fast_bus_word == 64'd0, "fast bus word set on another kind")

  `I2CM_ASSERT_SAME(a_await_last, !empty && (kind == i2cm_pkg::K_AWAIT || kind == i2cm_pkg::K_DONE), last && control_word == 6'd0, "await or finish word not last")

  `I2CM_ASSERT_SAME(a_nack_shape, !empty && nack_error, kind == i2cm_pkg::K_DONE && read_data == 8'd0, "error on a bad result")

endmodule

bind i2c_master_fast_write_and_bitbang_read i2cm_checker u_i2cm_checker (.*);

### test/i2c_master_fast_write_and_bitbang_read_checker.sv
`timescale 1ns / 1ps

module i2c_master_fast_write_and_bitbang_read_checker #(
  parameter logic [2:0] SENSOR_ADDR_REG = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode,
  input  logic [7:0]  target_register,
  input  logic [7:0]  write_value,
  input  logic        sda_level,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  kind,
  input  logic [5:0]  control_word,
  input  logic [63:0] fast_bus_word,
  input  logic [7:0]  read_data,
  input  logic        nack_error,
  input  logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output logic [31:0] mismatches,
  output logic [31:0] words_due,
  output logic [31:0] useful_words
);
  import i2cm_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  cw;
    logic [63:0] fb;
    logic [7:0]  rd;
    logic        ne;
    logic        last;
  } bus_word_t;

  // Result words still to come from the block, oldest first.
  bus_word_t bus_words_due[$];
  // Result words caused by the request word being predicted.
  bus_word_t step_words[$];

  logic [7:0] sensor_addr_copy;
  logic       reading;
  logic [3:0] sample_step;
  logic [7:0] reg_latched;
  logic [7:0] data_shift;

  // Fast-bus encoding of the sensor address: every set bit ORs its own pattern in.
  function automatic logic [63:0] fast_address_bits(input logic [7:0] a);
    logic [63:0] w;
    w = 64'h1d20_8208_2082_082f;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) begin
        case (i)
          7: w = w | 64'h0000_0000_0000_1500;
          6: w = w | 64'h0000_0000_0005_4000;
          5: w = w | 64'h0000_0000_0150_0000;
          4: w = w | 64'h0000_0000_5400_0000;
          3: w = w | 64'h0000_0015_0000_0000;
          2: w = w | 64'h0000_0540_0000_0000;
          1: w = w | 64'h0001_5000_0000_0000;
          default: w = w | 64'h0054_0000_0000_0000;
        endcase
      end
    end
    return w;
  endfunction

  // Fast-bus encoding of a register or value byte, closed by the given tail word.
  function automatic logic [63:0] fast_byte_bits(input logic [7:0] b, input logic [15:0] tail);
    logic [63:0] w;
    w = {tail, 48'h2082_0820_8208};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        case (i)
          7: w = w | 64'h0000_0000_0000_0015;
          6: w = w | 64'h0000_0000_0000_0540;
          5: w = w | 64'h0000_0000_0001_5000;
          4: w = w | 64'h0000_0000_0054_0000;
          3: w = w | 64'h0000_0000_1500_0000;
          2: w = w | 64'h0000_0005_4000_0000;
          1: w = w | 64'h0000_0150_0000_0000;
          default: w = w | 64'h0000_5400_0000_0000;
        endcase
      end
    end
    return w;
  endfunction

  task automatic queue_word(input logic [1:0] k, input logic [5:0] cw, input logic [63:0] fb,
                            input logic [7:0] rd, input logic ne);
    bus_word_t w;
    w.kind = k;
    w.cw   = cw;
    w.fb   = fb;
    w.rd   = rd;
    w.ne   = ne;
    w.last = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic queue_ctl(input logic [5:0] cw);
    queue_word(K_CTL, cw, 64'd0, 8'd0, 1'b0);
  endtask

  task automatic queue_start();
    queue_ctl(CW_SDA0_SCL1);
    queue_ctl(CW_SDA0_SCL0);
  endtask

  task automatic queue_stop();
    queue_ctl(CW_SDA0_SCL0);
    queue_ctl(CW_SDA0_SCL1);
    queue_ctl(CW_SDA1_SCL1);
  endtask

  // Each bit goes out MSB first as clock low, high, low with SDA held.
  task automatic queue_serial_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      queue_ctl(b[i] ? CW_SDA1_SCL0 : CW_SDA0_SCL0);
      queue_ctl(b[i] ? CW_SDA1_SCL1 : CW_SDA0_SCL1);
      queue_ctl(b[i] ? CW_SDA1_SCL0 : CW_SDA0_SCL0);
    end
  endtask

  task automatic queue_sample_request();
    queue_ctl(CW_SDA1_SCL0);
    queue_ctl(CW_SDA1_SCL1);
    queue_word(K_AWAIT, 6'd0, 64'd0, 8'd0, 1'b0);
  endtask

  task automatic predict_bus_words(input logic [1:0] op, input logic [7:0] reg_sel,
                                   input logic [7:0] value, input logic level);
    bus_word_t w;
    step_words.delete();
    if (op == OP_WRITE && !reading) begin
      queue_word(K_FAST, 6'd0, fast_address_bits(sensor_addr_copy), 8'd0, 1'b0);
      queue_word(K_FAST, 6'd0, fast_byte_bits(reg_sel, TAIL_REGISTER), 8'd0, 1'b0);
      queue_word(K_FAST, 6'd0, fast_byte_bits(value, TAIL_VALUE), 8'd0, 1'b0);
    end else if (op == OP_READ && !reading) begin
      reading     = 1'b1;
      sample_step = STEP_ACK0;
      reg_latched = reg_sel;
      data_shift  = 8'd0;
      queue_ctl(CW_SDA1_SCL1);
      queue_start();
      queue_serial_byte(sensor_addr_copy);
      queue_sample_request();
    end else if (op == OP_SAMPLE && reading) begin
      queue_ctl(CW_SDA1_SCL0);
      if (sample_step <= STEP_ACK2) begin
        if (level) begin
          // Missing acknowledge: give up at once, no stop condition.
          queue_word(K_DONE, 6'd0, 64'd0, 8'd0, 1'b1);
          reading     = 1'b0;
          sample_step = STEP_ACK0;
        end else if (sample_step == STEP_ACK0) begin
          queue_serial_byte(reg_latched);
          queue_sample_request();
          sample_step = STEP_ACK1;
        end else if (sample_step == STEP_ACK1) begin
          // A stop, then a fresh start with the read address, which wraps at 8 bits.
          queue_stop();
          queue_start();
          queue_serial_byte(sensor_addr_copy + 8'd1);
          queue_sample_request();
          sample_step = STEP_ACK2;
        end else begin
          queue_ctl(CW_SDA1_SCL1);
          queue_word(K_AWAIT, 6'd0, 64'd0, 8'd0, 1'b0);
          sample_step = STEP_ACK2 + 4'd1;
        end
      end else begin
        data_shift = {data_shift[6:0], level};
        if (sample_step < STEP_LAST_BIT) begin
          queue_ctl(CW_SDA1_SCL1);
          queue_word(K_AWAIT, 6'd0, 64'd0, 8'd0, 1'b0);
          sample_step = sample_step + 4'd1;
        end else begin
          queue_ctl(CW_SDA1_SCL1);
          queue_ctl(CW_SDA1_SCL0);
          queue_stop();
          queue_ctl(CW_FAST_BUS);
          queue_word(K_DONE, 6'd0, 64'd0, data_shift, 1'b0);
          reading     = 1'b0;
          sample_step = STEP_ACK0;
        end
      end
    end
    for (int i = 0; i < step_words.size(); i++) begin
      w = step_words[i];
      w.last = (i == step_words.size() - 1);
      bus_words_due.push_back(w);
    end
    if (step_words.size() > 0) useful_words = useful_words + 1;
  endtask

  task automatic note_mismatch(input string what, input bus_word_t want, input bus_word_t got);
    mismatches = mismatches + 1;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected kind %0d cw %h fb %h rd %h ne %b last %b", $time, what,
               want.kind, want.cw, want.fb, want.rd, want.ne, want.last);
      $display("%0t: %s:      got kind %0d cw %h fb %h rd %h ne %b last %b", $time, what,
               got.kind, got.cw, got.fb, got.rd, got.ne, got.last);
    end
  endtask

  always @(posedge clk) begin
    bus_word_t got;
    bus_word_t want;
    if (rst) begin
      sensor_addr_copy = 8'd0;
      reading          = 1'b0;
      sample_step      = STEP_ACK0;
      reg_latched      = 8'd0;
      data_shift       = 8'd0;
      mismatches       = 0;
      useful_words     = 0;
      bus_words_due.delete();
    end else begin
      if (pop && !empty) begin
        got = {kind, control_word, fast_bus_word, read_data, nack_error, last};
        if (bus_words_due.size() == 0) begin
          want = '0;
          note_mismatch("unexpected result word", want, got);
        end else begin
          want = bus_words_due.pop_front();
          if (got.kind !== want.kind || got.cw !== want.cw || got.fb !== want.fb ||
              got.rd !== want.rd || got.ne !== want.ne || got.last !== want.last)
            note_mismatch("result word mismatch", want, got);
        end
      end
      if (push && !full) predict_bus_words(opcode, target_register, write_value, sda_level);
      if (psel && penable && pready && paddr == SENSOR_ADDR_REG) begin
        if (pwrite) begin
          sensor_addr_copy = pwdata[7:0];
        end else if (prdata[7:0] !== sensor_addr_copy) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: sensor address read back %h, expected %h", $time, prdata[7:0],
                     sensor_addr_copy);
        end
      end
    end
    words_due = bus_words_due.size();
  end

endmodule

### test/i2c_master_fast_write_and_bitbang_read_tb.sv
`timescale 1ns / 1ps

module i2c_master_fast_write_and_bitbang_read_tb;
  import i2cm_pkg::*;

  // Opcode 3 has no meaning; the block must drop such a word without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Byte address of the sensor address register on the configuration port.
  localparam logic [2:0] SENSOR_ADDR_REG = 3'd0;
  // Cycles without any word moving on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // After the last expected result has left, the bench still waits a little longer than
  // the longest script before touching the register.
  localparam int SETTLE_CYCLES = 40;
  // Request words that cause results, per random phase.
  localparam int WORDS_PER_PHASE = 120;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode = OP_WRITE;
  logic [7:0]  target_register = 8'd0;
  logic [7:0]  write_value = 8'd0;
  logic        sda_level = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [5:0]  control_word;
  logic [63:0] fast_bus_word;
  logic [7:0]  read_data;
  logic        nack_error;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = SENSOR_ADDR_REG;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] mismatches;
  logic [31:0] words_due;
  logic [31:0] useful_words;

  // Percent of cycles in which the request side holds back or the result side stalls.
  int send_idle_pct = 38;
  int recv_idle_pct = 50;
  // When set, read transactions get stray words mixed in between their samples.
  logic noisy = 1'b0;
  int   quiet_cycles = 0;

  i2c_master_fast_write_and_bitbang_read i_dut (.*);

  i2c_master_fast_write_and_bitbang_read_checker #(
    .SENSOR_ADDR_REG(SENSOR_ADDR_REG)
  ) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side pops at random; pop does not look at empty, as a queue reader may.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hang detection: any word moving on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one request word and returns at the falling edge after it was taken. Random
  // idle cycles come first, so push stays high between back-to-back words.
  task automatic send_word(input logic [1:0] op, input logic [7:0] reg_sel,
                           input logic [7:0] value, input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push            <= 1'b1;
    opcode          <= op;
    target_register <= reg_sel;
    write_value     <= value;
    sda_level       <= level;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // One SDA sample. In the random phases a stray request or an unused opcode now and
  // then lands in the middle of a read, where the block has to ignore it.
  task automatic send_sample(input logic level);
    int pick;
    if (noisy && $urandom_range(19) == 0) begin
      pick = $urandom_range(2);
      send_word(pick == 0 ? OP_WRITE : (pick == 1 ? OP_READ : OP_UNUSED),
                8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    send_word(OP_SAMPLE, 8'($urandom_range(255)), 8'($urandom_range(255)), level);
  endtask

  // A whole read: the request, three acknowledge samples and eight data bits. A high
  // level at acknowledge nack_at (0 to 2) ends it early; 3 means every one is low.
  task automatic read_transaction(input logic [7:0] reg_sel, input int nack_at,
                                  input logic [7:0] data);
    logic stopped;
    stopped = 1'b0;
    send_word(OP_READ, reg_sel, 8'($urandom_range(255)), 1'($urandom_range(1)));
    for (int i = 0; i < 3; i++) begin
      if (!stopped) begin
        send_sample(i == nack_at);
        stopped = (i == nack_at);
      end
    end
    if (!stopped) begin
      for (int i = 7; i >= 0; i--) send_sample(data[i]);
    end
  endtask

  // The register is only touched once every expected word is out and the block is quiet.
  // The value is read back right after the write so the checker can compare it.
  task automatic set_sensor_address(input logic [7:0] value);
    push <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= SENSOR_ADDR_REG;
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly whole writes and whole reads with random content. The rest is noise:
  // samples or unused opcodes with no read open, and reads broken off part way, which
  // leave the master waiting so that later requests get dropped.
  task automatic random_transaction();
    int pick;
    int r;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_word(OP_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
    end else if (pick < 80) begin
      r = $urandom_range(29);
      read_transaction(8'($urandom_range(255)), r < 3 ? r : 3, 8'($urandom_range(255)));
    end else if (pick < 90) begin
      send_word(pick < 85 ? OP_SAMPLE : OP_UNUSED, 8'($urandom_range(255)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      send_word(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
      r = $urandom_range(10);
      repeat (r) send_sample(1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [7:0] addr);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_sensor_address(addr);
    goal = useful_words + WORDS_PER_PHASE;
    while (useful_words < goal) random_transaction();
    // Eleven low samples close any read still open; surplus ones are simply dropped.
    repeat (11) send_word(OP_SAMPLE, 8'd0, 8'd0, 1'b0);
  endtask

  initial begin
    logic [7:0] pattern;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A write with the sensor address still at its reset value of zero.
    send_word(OP_WRITE, 8'h00, 8'hff, 1'b0);
    // All ones makes the read address wrap around to zero.
    set_sensor_address(8'hff);
    send_word(OP_WRITE, 8'hff, 8'h00, 1'b1);
    // A sample with no read open and an unused opcode are both dropped.
    send_word(OP_SAMPLE, 8'h00, 8'h00, 1'b1);
    send_word(OP_UNUSED, 8'hff, 8'hff, 1'b1);
    // A complete read, with a write request arriving while it is open.
    pattern = 8'hb2;
    send_word(OP_READ, 8'ha5, 8'h5a, 1'b1);
    send_word(OP_WRITE, 8'h3c, 8'hc3, 1'b0);
    repeat (3) send_word(OP_SAMPLE, 8'h00, 8'h00, 1'b0);
    for (int i = 7; i >= 0; i--) send_word(OP_SAMPLE, 8'hff, 8'hff, pattern[i]);
    // A missing acknowledge at each of the three acknowledge points.
    read_transaction(8'h5a, 0, 8'h00);
    read_transaction(8'h3c, 1, 8'h00);
    read_transaction(8'hc3, 2, 8'h00);

    noisy = 1'b1;
    run_phase(38, 50, 8'($urandom_range(255)));
    run_phase(50, 38, 8'h00);
    run_phase(0, 0, 8'($urandom_range(255)));

    push <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
